// ===== rtl/core/unsigned_radix_to_ascii_assert.svh =====
// Assertion macros for the radix-to-ASCII converter.
// Expect clk_i and rst_ni in the scope of use.
`ifndef UNSIGNED_RADIX_TO_ASCII_ASSERT_SVH
`define UNSIGNED_RADIX_TO_ASCII_ASSERT_SVH

// same-cycle implication
`define URA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define URA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ura_pkg.sv =====
// Shared constants and the digit-to-character mapping of the
// radix-to-ASCII converter. No dependencies.
package ura_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned IN_VALUE_W      = 32;
  localparam int unsigned RADIX_W         = 6;
  localparam int unsigned DIGIT_W         = 6;
  localparam int unsigned CHAR_W          = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC = 6'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(logic [DIGIT_W-1:0] d, logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
    if (d > DIGIT_MAX_DEC) begin
      return CHAR_W'(d - DIGIT_TEN) + base;
    end
    return CHAR_W'(d) + ASCII_ZERO;
  endfunction

endpackage

// ===== rtl/core/ura_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ura_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/unsigned_radix_to_ascii.sv =====
// Radix-to-ASCII converter top level: serial divider, digit RAM, emit sequencer.
// Depends on ura_pkg and ura_ram.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------
//  command  | start / busy        | value_i, radix_i, upper_case_i
//  result   | strobe_o (1 cycle)  | char_code_o, last_o, bad_radix_o
//
// Each digit is produced by the shared restore-subtract divider (one quotient
// bit per cycle); each character is then read back through the registered RAM
// read, in ST_RD and then ST_OUT.
// A bad radix gives its error beat in the cycle after acceptance and busy stays low.
// Reset is asynchronous; the digit RAM is not cleared. The receiver cannot stall.
module unsigned_radix_to_ascii #(
  parameter int unsigned VALUE_WIDTH = ura_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [ura_pkg::IN_VALUE_W-1:0]  value_i,
  input  logic [ura_pkg::RADIX_W-1:0]     radix_i,
  input  logic                            upper_case_i,
  output logic                            strobe_o,
  output logic [ura_pkg::CHAR_W-1:0]      char_code_o,
  output logic                            last_o,
  output logic                            bad_radix_o
);
  import ura_pkg::*;

  localparam int unsigned AW = $clog2(VALUE_WIDTH);
  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);
  localparam logic [AW-1:0] BIT_LAST   = AW'(VALUE_WIDTH - 1);
  localparam logic [CW-1:0] COUNT_LAST = CW'(VALUE_WIDTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [RADIX_W-1:0]     radix_q, radix_d;
  logic                   upper_q, upper_d;
  logic [AW-1:0]          bit_q, bit_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic                   strobe_q, strobe_d;
  logic [CHAR_W-1:0]      char_q, char_d;
  logic                   last_q, last_d;
  logic                   bad_q, bad_d;

  logic [63:0]            value_ext;
  logic [DIGIT_W:0]       trial;
  logic                   ge;
  logic [DIGIT_W-1:0]     rem_next;
  logic [VALUE_WIDTH-1:0] quot_next;
  logic                   radix_ok;
  logic                   ram_we, ram_re;
  logic [DIGIT_W-1:0]     ram_rdata;

  assign value_ext = 64'(value_i);
  assign radix_ok  = (radix_i >= RADIX_MIN) && (radix_i <= RADIX_MAX);

  // shared divider step: one quotient bit per cycle
  assign trial     = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign ge        = trial >= {1'b0, radix_q};
  assign rem_next  = ge ? DIGIT_W'(trial - {1'b0, radix_q}) : trial[DIGIT_W-1:0];
  assign quot_next = {quot_q[VALUE_WIDTH-2:0], ge};

  assign ram_we = (state_q == ST_DIV) && (bit_q == BIT_LAST);
  assign ram_re = (state_q == ST_RD);

  ura_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (rem_next),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    quot_d   = quot_q;
    rem_d    = rem_q;
    radix_d  = radix_q;
    upper_d  = upper_q;
    bit_d    = bit_q;
    count_d  = count_q;
    idx_d    = idx_q;
    strobe_d = 1'b0;
    char_d   = char_q;
    last_d   = last_q;
    bad_d    = bad_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (radix_ok) begin
            quot_d  = value_ext[VALUE_WIDTH-1:0];
            rem_d   = '0;
            radix_d = radix_i;
            upper_d = upper_case_i;
            bit_d   = '0;
            count_d = '0;
            state_d = ST_DIV;
          end else begin
            strobe_d = 1'b1;
            char_d   = '0;
            last_d   = 1'b1;
            bad_d    = 1'b1;
          end
        end
      end
      ST_DIV: begin
        quot_d = quot_next;
        rem_d  = rem_next;
        bit_d  = bit_q + 1'b1;
        if (bit_q == BIT_LAST) begin
          rem_d   = '0;
          bit_d   = '0;
          count_d = count_q + 1'b1;
          if ((quot_next == '0) || (count_q == COUNT_LAST)) begin
            idx_d   = count_q[AW-1:0];
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        strobe_d = 1'b1;
        char_d   = digit_to_ascii(ram_rdata, upper_q);
        last_d   = (idx_q == '0);
        bad_d    = 1'b0;
        idx_d    = idx_q - 1'b1;
        state_d  = (idx_q == '0) ? ST_IDLE : ST_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      quot_q   <= '0;
      count_q  <= '0;
      bit_q    <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      quot_q   <= quot_d;
      count_q  <= count_d;
      bit_q    <= bit_d;
      idx_q    <= idx_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    radix_q <= radix_d;
    upper_q <= upper_d;
    char_q  <= char_d;
    last_q  <= last_d;
    bad_q   <= bad_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign strobe_o    = strobe_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;
  assign bad_radix_o = bad_q;

endmodule

// ===== rtl/core/ura_checker.sv =====
// Port-level checks for the radix-to-ASCII converter, bound to the top level.
// Depends on ura_pkg and unsigned_radix_to_ascii_assert.svh.
`include "unsigned_radix_to_ascii_assert.svh"

module ura_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       strobe_o,
  input logic [ura_pkg::CHAR_W-1:0] char_code_o,
  input logic                       last_o,
  input logic                       bad_radix_o
);
  import ura_pkg::*;

  logic is_digit_char;

  assign is_digit_char =
      ((char_code_o >= ASCII_ZERO)    && (char_code_o <= ASCII_NINE))    ||
      ((char_code_o >= ASCII_UPPER_A) && (char_code_o <= ASCII_UPPER_Z)) ||
      ((char_code_o >= ASCII_LOWER_A) && (char_code_o <= ASCII_LOWER_Z));

  `URA_ASSERT_SAME(a_err_beat, strobe_o && bad_radix_o, last_o && char_code_o == '0, "error beat malformed")
  `URA_ASSERT_SAME(a_char_range, strobe_o && !bad_radix_o, is_digit_char, "beat is not a digit character")
  `URA_ASSERT_NEXT(a_start_resp, start && !busy, busy || (strobe_o && bad_radix_o), "accepted command gave no work")
  `URA_ASSERT_SAME(a_end_last, $fell(busy), strobe_o && last_o, "conversion ended without last beat")

endmodule

bind unsigned_radix_to_ascii ura_checker u_ura_checker (.*);
